[rtl/lfpd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpd_pkg
// Types and constants shared by the line follower PD steering block.
// ----------------------------------------------------------------------------
package lfpd_pkg;

	localparam int SensorCount  = 8;
	localparam int HalfCount    = SensorCount / 2;
	localparam int LineCenter   = (SensorCount - 1) * 500;
	localparam int MaxDarkCount = 3;
	localparam int DarkCntW     = $clog2(SensorCount + 1);
	localparam int SensorW      = 10;
	localparam int SumW         = SensorW + $clog2(HalfCount);
	localparam int PosW         = 13;
	localparam int ErrW         = 13;
	localparam int ErrMax       = 4095;
	localparam int ErrMin       = -4096;
	localparam int CfgIdxW      = 3;
	localparam int CfgDataW     = 10;

	typedef enum logic [1:0] {
		MODE_FOLLOW     = 2'd0,
		MODE_SPIN_LEFT  = 2'd1,
		MODE_SPIN_RIGHT = 2'd2,
		MODE_HOLD       = 2'd3
	} drive_mode_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_RIGHT_BASE  = 3'd0,
		REG_LEFT_BASE   = 3'd1,
		REG_RIGHT_MAX   = 3'd2,
		REG_LEFT_MAX    = 3'd3,
		REG_SPIN_SPEED  = 3'd4,
		REG_PROP_GAIN   = 3'd5,
		REG_DERIV_GAIN  = 3'd6,
		REG_DARK_THRESH = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [PosW-1:0]    line_position;
		logic [SensorW-1:0] sensor_0;
		logic [SensorW-1:0] sensor_1;
		logic [SensorW-1:0] sensor_2;
		logic [SensorW-1:0] sensor_3;
		logic [SensorW-1:0] sensor_4;
		logic [SensorW-1:0] sensor_5;
		logic [SensorW-1:0] sensor_6;
		logic [SensorW-1:0] sensor_7;
	} sample_t;

	typedef struct packed {
		drive_mode_t drive_mode;
		logic [7:0]  right_speed;
		logic [7:0]  left_speed;
	} cmd_t;

	typedef struct packed {
		logic [7:0]         right_base_speed;
		logic [7:0]         left_base_speed;
		logic [7:0]         right_max_speed;
		logic [7:0]         left_max_speed;
		logic [7:0]         spin_speed;
		logic [7:0]         prop_gain;
		logic [7:0]         deriv_gain;
		logic [SensorW-1:0] dark_threshold;
	} cfg_t;

	typedef struct packed {
		logic                   err_update;
		logic signed [ErrW-1:0] err;
		logic                   arm_left_spin;
	} steer_state_t;

endpackage

[rtl/lfpd_steer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpd_steer
// Single-pass steering decision: dark count, half sums, PD correction, clamp.
// ----------------------------------------------------------------------------
module lfpd_steer import lfpd_pkg::*; (
	input  sample_t                sample,
	input  cfg_t                   cfg,
	input  logic signed [ErrW-1:0] prev_err,
	input  logic                   left_spin_armed,
	output cmd_t                   cmd,
	output steer_state_t           next_state
);

	logic [SensorW-1:0]      sens [SensorCount];
	logic [DarkCntW-1:0]     dark_cnt;
	logic [SumW-1:0]         left_sum;
	logic [SumW-1:0]         right_sum;
	logic signed [PosW:0]    pos_err;
	logic signed [ErrW-1:0]  err;
	logic signed [ErrW:0]    diff;
	logic signed [21:0]      prod_p;
	logic signed [22:0]      prod_d;
	logic signed [22:0]      acc;
	logic signed [22:0]      acc_adj;
	logic signed [14:0]      corr;
	logic signed [15:0]      rs_sum;
	logic signed [15:0]      ls_sum;

	assign sens[0] = sample.sensor_0;
	assign sens[1] = sample.sensor_1;
	assign sens[2] = sample.sensor_2;
	assign sens[3] = sample.sensor_3;
	assign sens[4] = sample.sensor_4;
	assign sens[5] = sample.sensor_5;
	assign sens[6] = sample.sensor_6;
	assign sens[7] = sample.sensor_7;

	always_comb begin
		dark_cnt  = '0;
		left_sum  = '0;
		right_sum = '0;
		for (int i = 0; i < SensorCount; i++) begin
			if (sens[i] < cfg.dark_threshold) begin
				dark_cnt = dark_cnt + DarkCntW'(1);
			end
			if (i < HalfCount) begin
				left_sum = left_sum + SumW'(sens[i]);
			end else begin
				right_sum = right_sum + SumW'(sens[i]);
			end
		end
	end

	always_comb begin
		pos_err = $signed({1'b0, sample.line_position}) - (PosW+1)'(LineCenter);
		if (pos_err > (PosW+1)'(ErrMax)) begin
			err = ErrW'(ErrMax);
		end else if (pos_err < (PosW+1)'(ErrMin)) begin
			err = ErrW'(ErrMin);
		end else begin
			err = pos_err[ErrW-1:0];
		end
		diff    = {err[ErrW-1], err} - {prev_err[ErrW-1], prev_err};
		prod_p  = $signed({1'b0, cfg.prop_gain}) * err;
		prod_d  = $signed({1'b0, cfg.deriv_gain}) * diff;
		acc     = {prod_p[21], prod_p} + prod_d;
		acc_adj = acc[22] ? acc + 23'sd255 : acc;
		corr    = acc_adj[22:8];
		rs_sum  = $signed({8'b0, cfg.right_base_speed}) + {corr[14], corr};
		ls_sum  = $signed({8'b0, cfg.left_base_speed}) - {corr[14], corr};
	end

	always_comb begin
		cmd        = '{drive_mode: MODE_HOLD, right_speed: 8'd0, left_speed: 8'd0};
		next_state = '{err_update: 1'b0, err: err, arm_left_spin: 1'b0};
		if (dark_cnt <= DarkCntW'(MaxDarkCount)) begin
			cmd.drive_mode        = MODE_FOLLOW;
			next_state.err_update = 1'b1;
			if (rs_sum > $signed({8'b0, cfg.right_max_speed})) begin
				cmd.right_speed = cfg.right_max_speed;
			end else if (rs_sum < 16'sd0) begin
				cmd.right_speed = 8'd0;
			end else begin
				cmd.right_speed = rs_sum[7:0];
			end
			if (ls_sum > $signed({8'b0, cfg.left_max_speed})) begin
				cmd.left_speed = cfg.left_max_speed;
			end else if (ls_sum < 16'sd0) begin
				cmd.left_speed = 8'd0;
			end else begin
				cmd.left_speed = ls_sum[7:0];
			end
		end else if (left_sum > right_sum) begin
			next_state.arm_left_spin = 1'b1;
			if (left_spin_armed) begin
				cmd.drive_mode  = MODE_SPIN_LEFT;
				cmd.right_speed = cfg.spin_speed;
				cmd.left_speed  = cfg.spin_speed;
			end
		end else if (left_sum < right_sum) begin
			cmd.drive_mode  = MODE_SPIN_RIGHT;
			cmd.right_speed = cfg.spin_speed;
			cmd.left_speed  = cfg.spin_speed;
		end
	end

endmodule

[rtl/line_follower_pd_steering.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_follower_pd_steering
// PD steering and spin decisions for an eight-sensor line follower.
// ----------------------------------------------------------------------------
// Usage:
//  sample channel (sample_valid / sample_stall / sample) carries one tick's
//  line position and eight calibrated sensor values. cmd channel
//  (cmd_valid / cmd_stall / cmd) returns one drive command per sample.
//  A transfer happens on a rising edge with valid high and stall low.
//  A sample is held in the sample register, then its command in the command
//  register, which drives cmd_valid; one sample can be taken every cycle while
//  the command register is free. The decision logic sits between the two
//  registers; the stored error (follow mode only) and left-spin flag update as
//  a sample moves into the command register, so each sample sees all earlier.
//  cfg_valid / cfg_ready / cfg_index / cfg_data write the tuning registers;
//  cfg_ready is always high. Write only when idle.
//  Reset clears both stages, loads default tuning, zeroes the stored error
//  and disarms left spins. While cmd_stall holds, the command register and the
//  sample register fill, then sample_stall rises; nothing is dropped.
// ----------------------------------------------------------------------------
module line_follower_pd_steering import lfpd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  sample_t            sample,
	output logic               cmd_valid,
	input  logic               cmd_stall,
	output cmd_t               cmd,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgDataW-1:0] cfg_data
);

	cfg_t                   cfg_q;
	logic                   valid_s1;
	sample_t                sample_s1;
	logic                   cmd_valid_q;
	cmd_t                   cmd_q;
	logic signed [ErrW-1:0] prev_err_q;
	logic                   left_spin_armed_q;
	cmd_t                   cmd_next;
	steer_state_t           next_state;
	logic                   advance;
	logic                   out_free;

	assign out_free     = !cmd_valid_q || !cmd_stall;
	assign advance      = valid_s1 && out_free;
	assign sample_stall = valid_s1 && !out_free;
	assign cmd_valid    = cmd_valid_q;
	assign cmd          = cmd_q;
	assign cfg_ready    = 1'b1;

	lfpd_steer u_steer (
		.sample          (sample_s1),
		.cfg             (cfg_q),
		.prev_err        (prev_err_q),
		.left_spin_armed (left_spin_armed_q),
		.cmd             (cmd_next),
		.next_state      (next_state)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.right_base_speed <= 8'd60;
			cfg_q.left_base_speed  <= 8'd60;
			cfg_q.right_max_speed  <= 8'd85;
			cfg_q.left_max_speed   <= 8'd85;
			cfg_q.spin_speed       <= 8'd100;
			cfg_q.prop_gain        <= 8'd26;
			cfg_q.deriv_gain       <= 8'd179;
			cfg_q.dark_threshold   <= SensorW'(500);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_RIGHT_BASE:  cfg_q.right_base_speed <= cfg_data[7:0];
				REG_LEFT_BASE:   cfg_q.left_base_speed  <= cfg_data[7:0];
				REG_RIGHT_MAX:   cfg_q.right_max_speed  <= cfg_data[7:0];
				REG_LEFT_MAX:    cfg_q.left_max_speed   <= cfg_data[7:0];
				REG_SPIN_SPEED:  cfg_q.spin_speed       <= cfg_data[7:0];
				REG_PROP_GAIN:   cfg_q.prop_gain        <= cfg_data[7:0];
				REG_DERIV_GAIN:  cfg_q.deriv_gain       <= cfg_data[7:0];
				REG_DARK_THRESH: cfg_q.dark_threshold   <= cfg_data[SensorW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1          <= 1'b0;
			cmd_valid_q       <= 1'b0;
			prev_err_q        <= '0;
			left_spin_armed_q <= 1'b0;
		end else begin
			if (sample_valid && !sample_stall) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				cmd_valid_q <= 1'b1;
				if (next_state.err_update) begin
					prev_err_q <= next_state.err;
				end
				if (next_state.arm_left_spin) begin
					left_spin_armed_q <= 1'b1;
				end
			end else if (!cmd_stall) begin
				cmd_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			sample_s1 <= sample;
		end
		if (advance) begin
			cmd_q <= cmd_next;
		end
	end

endmodule
